// ===== rtl/core/rnc_pkg.sv =====
// ----------------------------------------------------------------------------
// rnc_pkg: shared types, constants and tables of the raster neighbor block
// Grid bounds, configuration register indexes, the cell descriptor that
// travels from the front to the back, and the neighbor offset tables.
// ----------------------------------------------------------------------------
package rnc_pkg;

  localparam int CELL_W    = 24;          // linear cell index width
  localparam int SIZE_W    = 13;          // grid size register width
  localparam int COORD_W   = 12;          // in-grid row/column width
  localparam int DIV_STEPS = CELL_W / 2;  // radix-4 divider iterations
  localparam int STEP_W    = 4;           // divider step counter width
  localparam int K_W       = 5;           // result counter, up to 17 results

  localparam logic [SIZE_W-1:0] MAX_COLS = 13'd4096;
  localparam logic [SIZE_W-1:0] MAX_ROWS = 13'd4096;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_NUM_COLS       = 3'd0,
    REG_NUM_ROWS       = 3'd1,
    REG_PATTERN        = 3'd2,
    REG_INCLUDE_CENTER = 3'd3,
    REG_WRAP_COLUMNS   = 3'd4
  } reg_index_t;

  // neighborhood patterns
  localparam logic [1:0] PAT_ROOK    = 2'd0;
  localparam logic [1:0] PAT_QUEEN   = 2'd1;
  localparam logic [1:0] PAT_BISHOP  = 2'd2;
  localparam logic [1:0] PAT_SIXTEEN = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] num_cols;     // clamped to 1..MAX_COLS
    logic [SIZE_W-1:0] num_rows;     // clamped to 1..MAX_ROWS
    logic [1:0]        pattern;
    logic              include_center;
    logic              wrap_columns;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0]  row;
    logic [COORD_W-1:0] col;
    logic [CELL_W-1:0]  cell_idx;
    logic               center_ok;
  } cell_desc_t;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
  } offset_t;

  localparam logic signed [2:0] ROOK_DR [4]   = '{-3'sd1, 3'sd0, 3'sd0, 3'sd1};
  localparam logic signed [2:0] ROOK_DC [4]   = '{3'sd0, -3'sd1, 3'sd1, 3'sd0};
  localparam logic signed [2:0] QUEEN_DR [8]  =
    '{-3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1};
  localparam logic signed [2:0] QUEEN_DC [8]  =
    '{-3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd1, -3'sd1, 3'sd0, 3'sd1};
  localparam logic signed [2:0] BISHOP_DR [4] = '{-3'sd1, -3'sd1, 3'sd1, 3'sd1};
  localparam logic signed [2:0] BISHOP_DC [4] = '{-3'sd1, 3'sd1, -3'sd1, 3'sd1};
  localparam logic signed [2:0] RING_DR [16]  =
    '{-3'sd2, -3'sd2, -3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd1, 3'sd0,
      3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2};
  localparam logic signed [2:0] RING_DC [16]  =
    '{-3'sd1, 3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2, -3'sd1,
      3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2, -3'sd1, 3'sd1};

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [K_W-1:0] pattern_count(input logic [1:0] pat);
    logic [K_W-1:0] n;
    case (pat)
      PAT_ROOK:   n = K_W'(4);
      PAT_QUEEN:  n = K_W'(8);
      PAT_BISHOP: n = K_W'(4);
      default:    n = K_W'(16);
    endcase
    return n;
  endfunction

  function automatic offset_t nbr_offset(input logic [1:0] pat, input logic [3:0] k);
    offset_t o;
    case (pat)
      PAT_ROOK: begin
        o.dr = ROOK_DR[k[1:0]];
        o.dc = ROOK_DC[k[1:0]];
      end
      PAT_QUEEN: begin
        o.dr = QUEEN_DR[k[2:0]];
        o.dc = QUEEN_DC[k[2:0]];
      end
      PAT_BISHOP: begin
        o.dr = BISHOP_DR[k[1:0]];
        o.dc = BISHOP_DC[k[1:0]];
      end
      default: begin
        o.dr = RING_DR[k];
        o.dc = RING_DC[k];
      end
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/core/rnc_front.sv =====
// ----------------------------------------------------------------------------
// rnc_front: cell intake and row/column split
// Accepts a linear cell index, divides it by the column count two quotient
// bits per cycle, classifies the cell as inside or outside the grid and
// hands the descriptor to the queue.
// ----------------------------------------------------------------------------
module rnc_front import rnc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic [CELL_W-1:0] cell_index,
  input  logic              cell_valid,
  output logic              cell_stall,
  output cell_desc_t        desc,
  output logic              push,
  input  logic              q_full
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [CELL_W-1:0] quo;
  logic [SIZE_W-1:0] rem;
  logic [CELL_W-1:0] cell_idx;
  logic              accept;

  logic [SIZE_W-1:0] rem_a;
  logic [SIZE_W-1:0] rem_b;
  logic              qb_a;
  logic              qb_b;

  // two restoring steps per cycle; rem stays below num_cols <= 4096
  always_comb begin
    rem_a = {rem[SIZE_W-2:0], quo[CELL_W-1]};
    qb_a  = (rem_a >= cfg.num_cols);
    if (qb_a) begin
      rem_a = rem_a - cfg.num_cols;
    end
    rem_b = {rem_a[SIZE_W-2:0], quo[CELL_W-2]};
    qb_b  = (rem_b >= cfg.num_cols);
    if (qb_b) begin
      rem_b = rem_b - cfg.num_cols;
    end
  end

  assign push       = done && !q_full;
  assign cell_stall = busy || (done && q_full);
  assign accept     = cell_valid && !cell_stall;

  assign desc.row       = quo;
  assign desc.col       = rem[COORD_W-1:0];
  assign desc.cell_idx  = cell_idx;
  assign desc.center_ok = (quo < {{(CELL_W-SIZE_W){1'b0}}, cfg.num_rows});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) begin
        done <= 1'b0;
      end
      if (busy) begin
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + STEP_W'(1);
        end
      end
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      quo      <= cell_index;
      rem      <= '0;
      cell_idx <= cell_index;
    end else if (busy) begin
      quo <= {quo[CELL_W-3:0], qb_a, qb_b};
      rem <= rem_b;
    end
  end

endmodule

// ===== rtl/core/rnc_queue.sv =====
// ----------------------------------------------------------------------------
// rnc_queue: two-entry descriptor queue
// Decouples the divider front from the neighbor sequencer.
// ----------------------------------------------------------------------------
module rnc_queue import rnc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cell_desc_t push_desc,
  output logic       full,
  input  logic       pop,
  output cell_desc_t head,
  output logic       head_valid
);

  cell_desc_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

endmodule

// ===== rtl/core/rnc_back.sv =====
// ----------------------------------------------------------------------------
// rnc_back: neighbor sequencer
// Walks the offset table of the configured pattern for the queue head, one
// neighbor per cycle unless nbr_stall holds it: offset and bounds check in
// one stage, row * num_cols plus column in the next, into the output register.
// ----------------------------------------------------------------------------
module rnc_back import rnc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  cell_desc_t        head,
  input  logic              head_valid,
  output logic              pop,
  output logic [CELL_W-1:0] neighbor_cell,
  output logic              in_grid,
  output logic              last,
  output logic              nbr_valid,
  input  logic              nbr_stall
);

  logic [K_W-1:0] k;
  logic [K_W-1:0] n;
  logic [K_W-1:0] total;
  logic           advance;
  logic           is_center;
  logic           is_last;
  offset_t        off;

  logic signed [CELL_W+1:0]  rr;
  logic signed [SIZE_W:0]    cc;
  logic                      row_ok;
  logic                      col_ok;
  logic                      ok;

  // stage one registers
  logic               s1_valid;
  logic               s1_ok;
  logic               s1_center;
  logic               s1_last;
  logic [COORD_W-1:0] s1_row;
  logic [COORD_W-1:0] s1_col;
  logic [CELL_W-1:0]  s1_cell;

  logic [COORD_W+SIZE_W-1:0] prod;
  logic [COORD_W+SIZE_W-1:0] lin;

  assign n         = pattern_count(cfg.pattern);
  assign total     = n + K_W'(cfg.include_center);
  assign is_center = (k == n);
  assign is_last   = (k == total - K_W'(1));
  assign off       = nbr_offset(cfg.pattern, k[3:0]);
  assign advance   = !nbr_valid || !nbr_stall;
  assign pop       = advance && head_valid && is_last;

  always_comb begin
    rr = $signed({2'b00, head.row}) + (CELL_W+2)'(signed'(off.dr));
    cc = $signed({2'b00, head.col}) + (SIZE_W+1)'(signed'(off.dc));
    if (cfg.wrap_columns) begin
      if (cfg.pattern == PAT_SIXTEEN) begin
        // column modulo num_cols; offsets never exceed two columns
        if (cfg.num_cols == SIZE_W'(1)) begin
          cc = '0;
        end else if (cc < 0) begin
          cc = cc + $signed({1'b0, cfg.num_cols});
        end else if (cc >= $signed({1'b0, cfg.num_cols})) begin
          cc = cc - $signed({1'b0, cfg.num_cols});
        end
      end else if (head.col == '0 && off.dc < 0) begin
        cc = $signed({1'b0, cfg.num_cols}) - (SIZE_W+1)'(1);
      end else if (head.col != '0 && {1'b0, head.col} == cfg.num_cols - SIZE_W'(1)
                   && off.dc > 0) begin
        cc = '0;
      end
    end
    row_ok = !rr[CELL_W+1] && (rr[CELL_W:0] < {{(CELL_W+1-SIZE_W){1'b0}}, cfg.num_rows});
    col_ok = !cc[SIZE_W] && (cc[SIZE_W-1:0] < cfg.num_cols);
    ok     = head.center_ok && row_ok && col_ok;
  end

  assign prod = {{SIZE_W{1'b0}}, s1_row} * {{COORD_W{1'b0}}, cfg.num_cols};
  assign lin  = prod + {{SIZE_W{1'b0}}, s1_col};

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      s1_valid  <= 1'b0;
      nbr_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= head_valid;
      nbr_valid <= s1_valid;
      if (head_valid) begin
        k <= is_last ? '0 : k + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ok     <= is_center ? head.center_ok : ok;
      s1_center <= is_center;
      s1_last   <= is_last;
      s1_row    <= rr[COORD_W-1:0];
      s1_col    <= cc[COORD_W-1:0];
      s1_cell   <= head.cell_idx;

      in_grid <= s1_ok;
      last    <= s1_last;
      if (!s1_ok) begin
        neighbor_cell <= '0;
      end else if (s1_center) begin
        neighbor_cell <= s1_cell;
      end else begin
        neighbor_cell <= lin[CELL_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/raster_neighbor_cells.sv =====
// ----------------------------------------------------------------------------
// raster_neighbor_cells: neighbor cell indices of a linear raster cell
// Splits a cell index into row and column and lists the linear indices of
// its rook, queen, bishop or sixteen-cell neighborhood.
// ----------------------------------------------------------------------------
// Usage:
//   Cell channel (cell_valid, cell_stall, cell_index) takes one linear cell
//   index per transaction. Neighbor channel (nbr_valid, nbr_stall) returns
//   one transaction per neighbor: neighbor_cell, in_grid, last; last marks
//   the final neighbor of a cell. Configuration writes go through cfg_valid,
//   cfg_ready, cfg_index and cfg_data; cfg_ready is always high and registers
//   should change only while the block is idle.
//   The front divides the index by num_cols in a radix-4 loop of 12 steps
//   and takes no new cell until it hands the last one to the queue; the
//   back emits one neighbor per cycle while nbr_stall is low, 4 to 17 per
//   cell. A two-entry queue lets both run in parallel.
//   Reset restores num_cols 4096, num_rows 4096, queen pattern, no center,
//   no wrapping, and empties the front, queue and back.
//   While nbr_stall and nbr_valid are high the back pipeline holds; the
//   front keeps dividing and fills the queue, then raises cell_stall.
// ----------------------------------------------------------------------------
module raster_neighbor_cells import rnc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cell_valid,
  output logic              cell_stall,
  input  logic [CELL_W-1:0] cell_index,
  output logic              nbr_valid,
  input  logic              nbr_stall,
  output logic [CELL_W-1:0] neighbor_cell,
  output logic              in_grid,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  // raw configuration registers
  logic [SIZE_W-1:0] num_cols;
  logic [SIZE_W-1:0] num_rows;
  logic [1:0]        pattern;
  logic              include_center;
  logic              wrap_columns;

  cfg_t       cfg;
  cell_desc_t front_desc;
  cell_desc_t head;
  logic       push;
  logic       q_full;
  logic       pop;
  logic       head_valid;

  // writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols       <= 13'd4096;
      num_rows       <= 13'd4096;
      pattern        <= PAT_QUEEN;
      include_center <= 1'b0;
      wrap_columns   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_NUM_COLS:       num_cols       <= cfg_data;
        REG_NUM_ROWS:       num_rows       <= cfg_data;
        REG_PATTERN:        pattern        <= cfg_data[1:0];
        REG_INCLUDE_CENTER: include_center <= cfg_data[0];
        REG_WRAP_COLUMNS:   wrap_columns   <= cfg_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // zero sizes act as one, oversized ones saturate at the grid bound
  assign cfg.num_cols       = clamp_size(num_cols, MAX_COLS);
  assign cfg.num_rows       = clamp_size(num_rows, MAX_ROWS);
  assign cfg.pattern        = pattern;
  assign cfg.include_center = include_center;
  assign cfg.wrap_columns   = wrap_columns;

  // front: intake and row/column divide
  rnc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cell_index (cell_index),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .desc       (front_desc),
    .push       (push),
    .q_full     (q_full)
  );

  // queue between divider and sequencer
  rnc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (front_desc),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // back: one neighbor per cycle into the output register unless stalled
  rnc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .neighbor_cell (neighbor_cell),
    .in_grid       (in_grid),
    .last          (last),
    .nbr_valid     (nbr_valid),
    .nbr_stall     (nbr_stall)
  );

endmodule
